[rtl/core/lfc_pkg.sv]
// Package for the LED frame command slave: shared codes, state types and
// the queue entry that passes from the front end to the back end.
// No dependencies.
package lfc_pkg;

  // Input action codes
  localparam logic [1:0] ACT_BYTE = 2'd0;
  localparam logic [1:0] ACT_TICK = 2'd1;
  localparam logic [1:0] ACT_READ = 2'd2;

  // Command codes
  localparam logic [7:0] CMD_CLEAR  = 8'd1;
  localparam logic [7:0] CMD_FILL   = 8'd2;
  localparam logic [7:0] CMD_UPDATE = 8'd3;
  localparam logic [7:0] CMD_PIXEL  = 8'd4;
  localparam logic [7:0] CMD_TEST   = 8'd6;

  // Response codes
  localparam logic [7:0] RSP_CMD_TAKEN = 8'h01;
  localparam logic [7:0] RSP_CHECK_OK  = 8'h02;
  localparam logic [7:0] RSP_ACK       = 8'h55;
  localparam logic [7:0] RSP_BAD_HEAD  = 8'haa;
  localparam logic [7:0] RSP_BAD_TAIL  = 8'hab;
  localparam logic [7:0] RSP_TIMEOUT   = 8'h44;

  // Check byte is the command inverted
  localparam logic [7:0] CHECK_MASK = 8'hff;

  // Reset value of the timeout limit
  localparam logic [7:0] TIMEOUT_RESET = 8'd2;

  // Classified operation handed to the back end
  typedef enum logic [1:0] {
    OP_BYTE,
    OP_TICK,
    OP_READ,
    OP_NOP
  } op_kind_t;

  // Framing phase
  typedef enum logic [1:0] {
    PH_WAIT,
    PH_CHECK,
    PH_PAYLOAD,
    PH_ACK
  } phase_t;

  // Back end sequencer state
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_SWEEP
  } back_state_t;

  typedef struct packed {
    op_kind_t    op;
    logic [7:0]  data_byte;
    logic [5:0]  read_index;
  } q_entry_t;

endpackage

[rtl/core/lfc_in_if.sv]
// Input channel of the LED frame command slave: valid/ready plus one item.
// No dependencies.
interface lfc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] data_byte;
  logic [5:0] read_index;

  modport source (output valid, output action, output data_byte, output read_index,
                  input ready);
  modport sink (input valid, input action, input data_byte, input read_index,
                output ready);
endinterface

[rtl/core/lfc_out_if.sv]
// Result channel of the LED frame command slave: valid/ready plus one item.
// No dependencies.
interface lfc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] rsp_byte;
  logic       response_load;
  logic       update_strobe;
  logic [7:0] read_green;
  logic [7:0] read_red;
  logic [7:0] read_blue;

  modport source (output valid, output rsp_byte, output response_load,
                  output update_strobe, output read_green, output read_red,
                  output read_blue, input ready);
  modport sink (input valid, input rsp_byte, input response_load,
                input update_strobe, input read_green, input read_red,
                input read_blue, output ready);
endinterface

[rtl/core/lfc_front.sv]
// Front end: accepts input items and classifies them into queue entries.
// Depends on lfc_pkg and lfc_in_if.
module lfc_front #(
  parameter int NUM_LEDS = 60
) (
  lfc_in_if.sink            in_ch,
  input  logic              q_full,
  output logic              q_push,
  output lfc_pkg::q_entry_t q_entry
);

  logic idx_in_range;

  // Reads past the end of the string return zeros, same as an unused action
  assign idx_in_range = 13'(in_ch.read_index) < 13'(NUM_LEDS);

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;

  // Classify the action
  always_comb begin
    q_entry.data_byte  = in_ch.data_byte;
    q_entry.read_index = in_ch.read_index;
    unique case (in_ch.action)
      lfc_pkg::ACT_BYTE: q_entry.op = lfc_pkg::OP_BYTE;
      lfc_pkg::ACT_TICK: q_entry.op = lfc_pkg::OP_TICK;
      lfc_pkg::ACT_READ: q_entry.op = idx_in_range ? lfc_pkg::OP_READ : lfc_pkg::OP_NOP;
      default:           q_entry.op = lfc_pkg::OP_NOP;
    endcase
  end

endmodule

[rtl/core/lfc_queue.sv]
// Two-entry queue between the front end and the back end.
// Depends on lfc_pkg.
module lfc_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  lfc_pkg::q_entry_t push_entry,
  output logic              full,
  input  logic              pop,
  output lfc_pkg::q_entry_t pop_entry,
  output logic              empty
);

  lfc_pkg::q_entry_t slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full      = cnt_r == 2'd2;
  assign empty     = cnt_r == 2'd0;
  assign pop_entry = slot_r[rd_ptr_r];

  // Pointer and count update
  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

[rtl/core/lfc_back.sv]
// Back end: framing machine, frame store with clear/fill sweep, and the
// result register. Depends on lfc_pkg and lfc_out_if.
module lfc_back #(
  parameter int PANEL_WIDTH  = 10,
  parameter int PANEL_HEIGHT = 6
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  lfc_pkg::q_entry_t q_entry,
  output logic              q_pop,
  lfc_out_if.source         out_ch,
  input  logic              cfg_we,
  input  logic [7:0]        cfg_data
);

  localparam int NUM_LEDS = PANEL_WIDTH * PANEL_HEIGHT;
  localparam int AW = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
  localparam logic [AW-1:0] SWEEP_LAST = AW'(NUM_LEDS - 1);

  lfc_pkg::back_state_t state_r, state_nxt;
  lfc_pkg::phase_t      phase_r, phase_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [7:0]  count_r, count_nxt;
  logic [7:0]  last_rsp_r, last_rsp_nxt;
  logic [7:0]  idle_r, idle_nxt;
  logic [7:0]  pend_x_r, pend_x_nxt;
  logic [7:0]  pend_y_r, pend_y_nxt;
  logic [7:0]  pend_red_r, pend_red_nxt;
  logic [7:0]  pend_green_r, pend_green_nxt;
  logic [7:0]  timeout_r, timeout_nxt;
  logic [AW-1:0] sweep_cnt_r, sweep_cnt_nxt;
  logic [23:0] sweep_color_r, sweep_color_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  rsp_r, rsp_nxt;
  logic        load_r, load_nxt;
  logic        strobe_r, strobe_nxt;
  logic [23:0] color_r, color_nxt;

  // Frame store, word = {green, red, blue}
  logic [23:0]   store_mem [NUM_LEDS];
  logic [23:0]   rd_data_r;
  logic [AW-1:0] rd_addr;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [23:0]   mem_wdata;

  logic          slot_free;
  logic [7:0]    idle_inc;
  logic          pl_done;
  logic          pl_fail;
  logic [5:0]    pix_x;
  logic [5:0]    pix_y;
  logic [5:0]    pix_col;
  logic [12:0]   pix_pos;
  logic          pix_in_panel;

  assign slot_free = !out_valid_r || out_ch.ready;
  assign idle_inc  = (idle_r == 8'hff) ? idle_r : idle_r + 8'd1;
  assign rd_addr   = AW'(q_entry.read_index);

  // Serpentine position: odd rows run left to right, even rows reversed
  assign pix_x        = pend_x_r[5:0];
  assign pix_y        = pend_y_r[5:0];
  assign pix_in_panel = (pend_x_r < 8'(PANEL_WIDTH)) && (pend_y_r < 8'(PANEL_HEIGHT));
  assign pix_col      = pix_y[0] ? pix_x : (6'(PANEL_WIDTH - 1) - pix_x);
  assign pix_pos      = 13'(pix_y) * 13'(PANEL_WIDTH) + 13'(pix_col);

  // Result port
  assign out_ch.valid         = out_valid_r;
  assign out_ch.rsp_byte      = rsp_r;
  assign out_ch.response_load = load_r;
  assign out_ch.update_strobe = strobe_r;
  assign out_ch.read_green    = color_r[23:16];
  assign out_ch.read_red      = color_r[15:8];
  assign out_ch.read_blue     = color_r[7:0];

  // Sequencer, framing machine and result selection
  always_comb begin
    state_nxt       = state_r;
    phase_nxt       = phase_r;
    cmd_nxt         = cmd_r;
    count_nxt       = count_r;
    last_rsp_nxt    = last_rsp_r;
    idle_nxt        = idle_r;
    pend_x_nxt      = pend_x_r;
    pend_y_nxt      = pend_y_r;
    pend_red_nxt    = pend_red_r;
    pend_green_nxt  = pend_green_r;
    timeout_nxt     = cfg_we ? cfg_data : timeout_r;
    sweep_cnt_nxt   = sweep_cnt_r;
    sweep_color_nxt = sweep_color_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    rsp_nxt         = rsp_r;
    load_nxt        = load_r;
    strobe_nxt      = strobe_r;
    color_nxt       = color_r;
    q_pop           = 1'b0;
    mem_we          = 1'b0;
    mem_waddr       = sweep_cnt_r;
    mem_wdata       = sweep_color_r;
    pl_done         = 1'b0;
    pl_fail         = 1'b0;

    unique case (state_r)
      lfc_pkg::BK_SWEEP: begin
        // Paint one LED per cycle
        mem_we = 1'b1;
        if (sweep_cnt_r == SWEEP_LAST) begin
          sweep_cnt_nxt = '0;
          state_nxt     = lfc_pkg::BK_IDLE;
        end else begin
          sweep_cnt_nxt = sweep_cnt_r + AW'(1);
        end
      end

      lfc_pkg::BK_READ: begin
        // Store data is back; slot was freed when the read was issued
        out_valid_nxt = 1'b1;
        rsp_nxt       = 8'd0;
        load_nxt      = 1'b0;
        strobe_nxt    = 1'b0;
        color_nxt     = rd_data_r;
        state_nxt     = lfc_pkg::BK_IDLE;
      end

      lfc_pkg::BK_IDLE: begin
        if (!q_empty && slot_free) begin
          q_pop         = 1'b1;
          out_valid_nxt = 1'b1;
          rsp_nxt       = 8'd0;
          load_nxt      = 1'b0;
          strobe_nxt    = 1'b0;
          color_nxt     = 24'd0;
          case (q_entry.op)
            lfc_pkg::OP_BYTE: begin
              idle_nxt = 8'd0;
              load_nxt = 1'b1;
              unique case (phase_r)
                lfc_pkg::PH_WAIT: begin
                  last_rsp_nxt = lfc_pkg::RSP_CMD_TAKEN;
                  count_nxt    = 8'd0;
                  cmd_nxt      = q_entry.data_byte;
                  phase_nxt    = lfc_pkg::PH_CHECK;
                end
                lfc_pkg::PH_CHECK: begin
                  if (q_entry.data_byte == (cmd_r ^ lfc_pkg::CHECK_MASK)) begin
                    last_rsp_nxt = lfc_pkg::RSP_CHECK_OK;
                    phase_nxt    = lfc_pkg::PH_PAYLOAD;
                  end else begin
                    last_rsp_nxt = lfc_pkg::RSP_BAD_HEAD;
                    phase_nxt    = lfc_pkg::PH_WAIT;
                  end
                end
                lfc_pkg::PH_PAYLOAD: begin
                  unique case (cmd_r)
                    lfc_pkg::CMD_CLEAR: begin
                      pl_done         = 1'b1;
                      sweep_color_nxt = 24'd0;
                      state_nxt       = lfc_pkg::BK_SWEEP;
                    end
                    lfc_pkg::CMD_FILL: begin
                      if (count_r == 8'd0) begin
                        pend_red_nxt = q_entry.data_byte;
                      end else if (count_r == 8'd1) begin
                        pend_green_nxt = q_entry.data_byte;
                      end else if (count_r == 8'd2) begin
                        pl_done         = 1'b1;
                        sweep_color_nxt = {pend_green_r, pend_red_r, q_entry.data_byte};
                        state_nxt       = lfc_pkg::BK_SWEEP;
                      end else begin
                        pl_fail = 1'b1;
                      end
                    end
                    lfc_pkg::CMD_UPDATE: begin
                      pl_done    = 1'b1;
                      strobe_nxt = 1'b1;
                    end
                    lfc_pkg::CMD_PIXEL: begin
                      if (count_r == 8'd0) begin
                        pend_x_nxt = q_entry.data_byte;
                      end else if (count_r == 8'd1) begin
                        pend_y_nxt = q_entry.data_byte;
                      end else if (count_r == 8'd2) begin
                        pend_red_nxt = q_entry.data_byte;
                      end else if (count_r == 8'd3) begin
                        pend_green_nxt = q_entry.data_byte;
                      end else if (count_r == 8'd4) begin
                        // Off-panel writes are dropped but still acknowledged
                        pl_done   = 1'b1;
                        mem_we    = pix_in_panel;
                        mem_waddr = AW'(pix_pos);
                        mem_wdata = {pend_green_r, pend_red_r, q_entry.data_byte};
                      end else begin
                        pl_fail = 1'b1;
                      end
                    end
                    lfc_pkg::CMD_TEST: begin
                      pl_done = 1'b1;
                    end
                    default: begin
                      pl_fail = 1'b1;
                    end
                  endcase
                  count_nxt    = count_r + 8'd1;
                  last_rsp_nxt = count_r;
                  if (pl_fail) begin
                    phase_nxt    = lfc_pkg::PH_ACK;
                    last_rsp_nxt = lfc_pkg::RSP_BAD_TAIL;
                  end else if (pl_done) begin
                    phase_nxt    = lfc_pkg::PH_ACK;
                    last_rsp_nxt = lfc_pkg::RSP_ACK;
                  end
                end
                lfc_pkg::PH_ACK: begin
                  // Repeat the final response and rearm
                  phase_nxt = lfc_pkg::PH_WAIT;
                end
                default: begin
                  phase_nxt = lfc_pkg::PH_WAIT;
                end
              endcase
              rsp_nxt = last_rsp_nxt;
            end

            lfc_pkg::OP_TICK: begin
              idle_nxt = idle_inc;
              if (idle_inc > timeout_r) begin
                phase_nxt    = lfc_pkg::PH_WAIT;
                last_rsp_nxt = 8'd0;
                rsp_nxt      = lfc_pkg::RSP_TIMEOUT;
                load_nxt     = 1'b1;
              end
            end

            lfc_pkg::OP_READ: begin
              // Result goes out once the registered read returns
              out_valid_nxt = 1'b0;
              state_nxt     = lfc_pkg::BK_READ;
            end

            default: begin
            end
          endcase
        end
      end

      default: begin
        state_nxt = lfc_pkg::BK_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= lfc_pkg::BK_SWEEP;
      phase_r       <= lfc_pkg::PH_WAIT;
      cmd_r         <= 8'd0;
      count_r       <= 8'd0;
      last_rsp_r    <= 8'd0;
      idle_r        <= 8'd0;
      pend_x_r      <= 8'd0;
      pend_y_r      <= 8'd0;
      pend_red_r    <= 8'd0;
      pend_green_r  <= 8'd0;
      timeout_r     <= lfc_pkg::TIMEOUT_RESET;
      sweep_cnt_r   <= '0;
      sweep_color_r <= 24'd0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      phase_r       <= phase_nxt;
      cmd_r         <= cmd_nxt;
      count_r       <= count_nxt;
      last_rsp_r    <= last_rsp_nxt;
      idle_r        <= idle_nxt;
      pend_x_r      <= pend_x_nxt;
      pend_y_r      <= pend_y_nxt;
      pend_red_r    <= pend_red_nxt;
      pend_green_r  <= pend_green_nxt;
      timeout_r     <= timeout_nxt;
      sweep_cnt_r   <= sweep_cnt_nxt;
      sweep_color_r <= sweep_color_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    rsp_r    <= rsp_nxt;
    load_r   <= load_nxt;
    strobe_r <= strobe_nxt;
    color_r  <= color_nxt;
  end

  // Frame store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= store_mem[rd_addr];
  end

  // Pops only happen from idle with a queued item
  a_pop_legal: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (state_r == lfc_pkg::BK_IDLE) && !q_empty)
    else $error("queue popped outside idle or while empty");

  // Read data lands in an empty result slot
  a_read_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lfc_pkg::BK_READ) |-> !out_valid_r)
    else $error("read result would overwrite a pending result");

  // A sweep runs to the last LED without interruption
  a_sweep_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lfc_pkg::BK_SWEEP) && (sweep_cnt_r != SWEEP_LAST)
      |=> (state_r == lfc_pkg::BK_SWEEP))
    else $error("store sweep cut short");

  // The acknowledge phase always holds a final response
  a_ack_rsp: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == lfc_pkg::PH_ACK)
      |-> (last_rsp_r == lfc_pkg::RSP_ACK) || (last_rsp_r == lfc_pkg::RSP_BAD_TAIL))
    else $error("acknowledge phase without final response");

endmodule

[rtl/core/led_frame_command_slave.sv]
// Top level of the LED frame command slave: front end, queue, back end.
// Depends on lfc_pkg, lfc_in_if, lfc_out_if, lfc_front, lfc_queue, lfc_back.
//
// Usage:
//   in_ch  carries one item per valid/ready handshake: a byte from the serial
//          master, a millisecond tick, or a read of one stored LED.
//   out_ch returns exactly one result per item, in order: the response byte
//          to load (with its load flag), the update strobe, and read colors.
//   cfg_we/cfg_data write the timeout limit in idle ticks (reset value 2).
// Timing: a result is held in the output register; an LED read passes through
//   the registered store read first. A clear or fill command then
//   repaints the frame store one LED per cycle, all PANEL_WIDTH*PANEL_HEIGHT
//   LEDs (60 by default), before the next item is executed.
// Items: a new item is taken as the last result leaves, except in a read or sweep.
// Reset: the store is cleared by the same sweep over all LEDs;
//   up to two items are queued meanwhile and wait.
// Stalls: a result waits in the output register while out_ch.ready is low;
//   the two-entry queue keeps taking items until it fills.
module led_frame_command_slave #(
  parameter int PANEL_WIDTH  = 10,
  parameter int PANEL_HEIGHT = 6
) (
  input  logic       clk,
  input  logic       rst_n,
  lfc_in_if.sink     in_ch,
  lfc_out_if.source  out_ch,
  input  logic       cfg_we,
  input  logic [7:0] cfg_data
);

  localparam int NUM_LEDS = PANEL_WIDTH * PANEL_HEIGHT;

  logic              q_push;
  logic              q_full;
  logic              q_pop;
  logic              q_empty;
  lfc_pkg::q_entry_t push_entry;
  lfc_pkg::q_entry_t pop_entry;

  // Classify incoming items
  lfc_front #(
    .NUM_LEDS (NUM_LEDS)
  ) u_front (
    .in_ch   (in_ch),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_entry (push_entry)
  );

  // Decoupling queue
  lfc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .pop_entry  (pop_entry),
    .empty      (q_empty)
  );

  // Execute items
  lfc_back #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_entry  (pop_entry),
    .q_pop    (q_pop),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

endmodule
